[rtl/vnr_pkg.sv]
`default_nettype none
package vnr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_X = 3'd0;
  localparam logic [2:0] REG_SRC_Y = 3'd1;
  localparam logic [2:0] REG_SRC_Z = 3'd2;
  localparam logic [2:0] REG_DST_X = 3'd3;
  localparam logic [2:0] REG_DST_Y = 3'd4;
  localparam logic [2:0] REG_DST_Z = 3'd5;

  localparam int unsigned SRC_REG_BITS = 6;
  localparam int unsigned DST_REG_BITS = 13;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned VOXEL_BITS = 8;
  localparam int unsigned NUM_AXES = 3;

  localparam logic [SRC_REG_BITS-1:0] SRC_RESET = 6'd32;
  localparam logic [DST_REG_BITS-1:0] DST_RESET = 13'd32;

  typedef enum logic {
    ACT_STORE = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_STORE     = 2'd0,
    KIND_READ      = 2'd1,
    KIND_RANGE_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [COORD_BITS-1:0] coord_z;
    logic [VOXEL_BITS-1:0] voxel_in;
  } item_t;

  typedef struct packed {
    logic [VOXEL_BITS-1:0] voxel_out;
    logic                  range_error;
  } result_t;

  // classified operation between front and back
  typedef struct packed {
    kind_e                                     kind;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]       coord;
    logic [NUM_AXES-1:0][SRC_REG_BITS-1:0]     src_size;
    logic [VOXEL_BITS-1:0]                     data;
  } op_t;

endpackage
`default_nettype wire

[rtl/vnr_ram.sv]
`default_nettype none
module vnr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[rtl/vnr_fifo.sv]
`default_nettype none
module vnr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

[rtl/vnr_front.sv]
`default_nettype none
module vnr_front #(
  parameter int unsigned MAX_SIDE       = 32,
  parameter int unsigned DST_COORD_BITS = 12
) (
  input  wire logic                                                       push_i,
  input  wire vnr_pkg::item_t                                             item_i,
  input  wire logic [vnr_pkg::NUM_AXES-1:0][vnr_pkg::SRC_REG_BITS-1:0]    src_reg_i,
  input  wire logic [vnr_pkg::NUM_AXES-1:0][vnr_pkg::DST_REG_BITS-1:0]    dst_reg_i,
  input  wire logic                                                       q_full_i,
  output logic                                                            q_push_o,
  output vnr_pkg::op_t                                                    op_o
);
  import vnr_pkg::*;

  localparam logic [COORD_BITS-1:0] CMASK = (DST_COORD_BITS >= COORD_BITS) ? '1 :
      COORD_BITS'((1 << DST_COORD_BITS) - 1);

  logic [NUM_AXES-1:0][COORD_BITS-1:0]   crd;
  logic [NUM_AXES-1:0][SRC_REG_BITS-1:0] eff;
  logic in_src, in_dst;

  always_comb begin
    crd[0] = item_i.coord_x & CMASK;
    crd[1] = item_i.coord_y & CMASK;
    crd[2] = item_i.coord_z & CMASK;
    in_src = 1'b1;
    in_dst = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      // clamp source size to 1..MAX_SIDE
      if (src_reg_i[a] == '0) begin
        eff[a] = SRC_REG_BITS'(1);
      end else if (MAX_SIDE < 64 && int'(src_reg_i[a]) > MAX_SIDE) begin
        eff[a] = SRC_REG_BITS'(MAX_SIDE);
      end else begin
        eff[a] = src_reg_i[a];
      end
      if (crd[a] >= COORD_BITS'(eff[a])) in_src = 1'b0;
      if (DST_REG_BITS'(crd[a]) >= dst_reg_i[a]) in_dst = 1'b0;
    end

    op_o.coord    = crd;
    op_o.src_size = eff;
    op_o.data     = item_i.voxel_in;
    if (item_i.action == ACT_STORE) begin
      op_o.kind = KIND_STORE;
    end else if (in_dst) begin
      op_o.kind = KIND_READ;
    end else begin
      op_o.kind = KIND_RANGE_ERR;
    end
    // stores outside the source volume are dropped here
    q_push_o = push_i && !q_full_i && ((item_i.action != ACT_STORE) || in_src);
  end
endmodule
`default_nettype wire

[rtl/vnr_back.sv]
`default_nettype none
module vnr_back #(
  parameter int unsigned MAX_SIDE  = 32,
  parameter int unsigned ELEM_BITS = 8,
  parameter int unsigned OUT_DEPTH = 16
) (
  input  wire logic                                                    clk_i,
  input  wire logic                                                    rst_ni,
  input  wire logic [vnr_pkg::NUM_AXES-1:0][vnr_pkg::DST_REG_BITS-1:0] dst_reg_i,
  input  wire logic                                                    q_empty_i,
  input  wire vnr_pkg::op_t                                            op_i,
  output logic                                                         q_pop_o,
  input  wire logic                                                    res_pop_i,
  output logic                                                         res_push_o,
  output vnr_pkg::result_t                                             res_o
);
  import vnr_pkg::*;

  localparam int unsigned QB    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = COORD_BITS + SRC_REG_BITS;
  localparam int unsigned RW    = (NW > DST_REG_BITS + QB) ? NW : DST_REG_BITS + QB;
  localparam int unsigned CW    = $clog2(OUT_DEPTH + 1);

  // credits cover results in flight plus those waiting in the result queue
  logic [CW-1:0] credit_q, credit_d;
  logic issue, issue_res;

  assign issue = !q_empty_i && ((op_i.kind == KIND_STORE) || (credit_q < CW'(OUT_DEPTH)));
  assign issue_res = issue && (op_i.kind != KIND_STORE);
  assign q_pop_o = issue;

  always_comb begin
    credit_d = credit_q;
    if (issue_res && !res_pop_i) begin
      credit_d = credit_q + 1'b1;
    end else if (res_pop_i && !issue_res) begin
      credit_d = credit_q - 1'b1;
    end
  end

  // stage 0 holds the products, stages 1..QB one quotient bit each
  logic  [QB:0]                    vld_q;
  kind_e                           kind_q [QB+1];
  logic  [VOXEL_BITS-1:0]          data_q [QB+1];
  logic  [NUM_AXES-1:0][RW-1:0]    rem_q  [QB+1];
  logic  [NUM_AXES-1:0][QB-1:0]    quo_q  [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      vld_q    <= '0;
    end else begin
      credit_q <= credit_d;
      vld_q    <= {vld_q[QB-1:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[0] <= op_i.kind;
    data_q[0] <= op_i.data;
    for (int a = 0; a < NUM_AXES; a++) begin
      rem_q[0][a] <= RW'(op_i.coord[a] * op_i.src_size[a]);
      // a store carries its source coordinate straight through
      quo_q[0][a] <= QB'(op_i.coord[a]);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int unsigned B = QB - 1 - k;
    logic [NUM_AXES-1:0][RW-1:0] rem_d;
    logic [NUM_AXES-1:0][QB-1:0] quo_d;
    logic [RW-1:0] dsh;

    always_comb begin
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      dsh   = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        dsh = RW'(dst_reg_i[a]) << B;
        if (kind_q[k] == KIND_READ) begin
          if (rem_q[k][a] >= dsh) begin
            rem_d[a]    = rem_q[k][a] - dsh;
            quo_d[a][B] = 1'b1;
          end else begin
            quo_d[a][B] = 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      kind_q[k+1] <= kind_q[k];
      data_q[k+1] <= data_q[k];
      rem_q[k+1]  <= rem_d;
      quo_q[k+1]  <= quo_d;
    end
  end

  // address stage
  logic                  a_vld_q, r_vld_q;
  kind_e                 a_kind_q, r_kind_q;
  logic [AW-1:0]         a_addr_q;
  logic [VOXEL_BITS-1:0] a_data_q;
  logic [ELEM_BITS-1:0]  rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_q[QB];
      r_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_kind_q <= kind_q[QB];
    a_data_q <= data_q[QB];
    a_addr_q <= AW'(quo_q[QB][2]) * AW'(MAX_SIDE * MAX_SIDE)
              + AW'(quo_q[QB][1]) * AW'(MAX_SIDE)
              + AW'(quo_q[QB][0]);
    r_kind_q <= a_kind_q;
  end

  vnr_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_vol (
    .clk_i   (clk_i),
    .we_i    (a_vld_q && (a_kind_q == KIND_STORE)),
    .addr_i  (a_addr_q),
    .wdata_i (ELEM_BITS'(a_data_q)),
    .rdata_o (rdata)
  );

  assign res_push_o        = r_vld_q && (r_kind_q != KIND_STORE);
  assign res_o.range_error = (r_kind_q == KIND_RANGE_ERR);
  assign res_o.voxel_out   = (r_kind_q == KIND_RANGE_ERR) ? '0 : VOXEL_BITS'(rdata);
endmodule
`default_nettype wire

[rtl/voxel_nearest_resampler.sv]
// nearest-neighbor 3-d volume resampler
// input queue: push/full carry one transaction of item_t; action 0 stores a
//   source voxel at (x,y,z), dropped when outside the source size; action 1
//   reads destination coordinate d and answers source voxel at
//   floor(d*src/dst) on each axis, or zero with range_error when d >= dst
// result queue: empty/pop; one result_t per read, none per store, in order
// config: cfg_we_i/cfg_idx_i/cfg_wdata_i write the six size registers; the
//   user must do so only while the block is idle, the block does not enforce it
// throughput: one transaction per cycle on both sides, unless full or the credits stall
// reads pass through a divider pipe that resolves one quotient bit per
//   stage
// reset: queues empty, sizes back to 32; the volume memory is not cleared,
//   a voxel must be stored before it is read
// receiver stall: results pile up in a 16-entry queue; the back end stops
//   issuing reads when its credits run out, then the middle queue fills and
//   full rises
`default_nettype none
module voxel_nearest_resampler #(
  parameter int unsigned MAX_SIDE       = 32,
  parameter int unsigned ELEM_BITS      = 8,
  parameter int unsigned DST_COORD_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire vnr_pkg::item_t                     in_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output vnr_pkg::result_t                        res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [2:0]                         cfg_idx_i,
  input  wire logic [vnr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import vnr_pkg::*;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;

  // size registers
  logic [NUM_AXES-1:0][SRC_REG_BITS-1:0] src_q;
  logic [NUM_AXES-1:0][DST_REG_BITS-1:0] dst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= {NUM_AXES{SRC_RESET}};
      dst_q <= {NUM_AXES{DST_RESET}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_X: src_q[0] <= cfg_wdata_i[SRC_REG_BITS-1:0];
        REG_SRC_Y: src_q[1] <= cfg_wdata_i[SRC_REG_BITS-1:0];
        REG_SRC_Z: src_q[2] <= cfg_wdata_i[SRC_REG_BITS-1:0];
        REG_DST_X: dst_q[0] <= cfg_wdata_i[DST_REG_BITS-1:0];
        REG_DST_Y: dst_q[1] <= cfg_wdata_i[DST_REG_BITS-1:0];
        REG_DST_Z: dst_q[2] <= cfg_wdata_i[DST_REG_BITS-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // front end: classify and drop out-of-volume stores
  logic mid_push, mid_full, mid_empty, mid_pop;
  op_t  mid_in, mid_out;

  vnr_front #(
    .MAX_SIDE       (MAX_SIDE),
    .DST_COORD_BITS (DST_COORD_BITS)
  ) u_front (
    .push_i    (push),
    .item_i    (in_i),
    .src_reg_i (src_q),
    .dst_reg_i (dst_q),
    .q_full_i  (mid_full),
    .q_push_o  (mid_push),
    .op_o      (mid_in)
  );

  assign full = mid_full;

  // short queue between classify and execute
  vnr_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_in),
    .pop_i   (mid_pop),
    .rdata_o (mid_out),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  // back end: multiply, divide, memory access
  logic    res_push, res_full;
  result_t res_in;

  vnr_back #(
    .MAX_SIDE  (MAX_SIDE),
    .ELEM_BITS (ELEM_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dst_reg_i  (dst_q),
    .q_empty_i  (mid_empty),
    .op_i       (mid_out),
    .q_pop_o    (mid_pop),
    .res_pop_i  (pop && !empty),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue, never overrun thanks to the back-end credits
  vnr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

  // res_full only matters to the credit scheme, which keeps it from blocking
  logic unused_full;
  assign unused_full = res_full;
endmodule
`default_nettype wire

[rtl/vnr_checker.sv]
`default_nettype none
module vnr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              push,
  input wire logic                              full,
  input wire vnr_pkg::item_t                    in_i,
  input wire logic                              empty,
  input wire logic                              pop,
  input wire vnr_pkg::result_t                  res_o,
  input wire logic                              cfg_we_i,
  input wire logic [2:0]                        cfg_idx_i,
  input wire logic [vnr_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import vnr_pkg::*;

  // an out-of-range read always carries a zero voxel
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.range_error) |-> (res_o.voxel_out == '0))
    else $error("range error with nonzero voxel");

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while stalled");

  // after reset the input side is not full and the result queue is empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (!full && empty))
    else $error("queue not empty after reset");

  // the input side can only fill up by taking a transaction
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("full rose without a push");

  logic unused_in;
  assign unused_in = ^{in_i, cfg_we_i, cfg_idx_i, cfg_wdata_i};
endmodule

bind voxel_nearest_resampler vnr_checker u_vnr_checker (.*);
`default_nettype wire
